@@ rtl/mse_pkg.sv @@
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants and types of the MIPS integer subset executor: opcode and
// function codes, configuration register indexes and the execute result.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int XLEN         = 32;
  localparam int REG_COUNT    = 32;
  localparam int REG_IDX_W    = 5;
  localparam int TEXT_WORDS_W = 21;
  localparam int CFG_ADDR_W   = 4;

  localparam logic [REG_IDX_W-1:0] LINK_REG = 5'd31;
  localparam logic [REG_IDX_W-1:0] ZERO_REG = 5'd0;

  localparam logic [XLEN-1:0]         TEXT_BASE_RST  = 32'h0040_0000;
  localparam logic [TEXT_WORDS_W-1:0] TEXT_WORDS_RST = 21'd0;
  localparam logic [XLEN-1:0]         DATA_BASE_RST  = 32'h1000_0000;

  localparam logic [1:0] CFG_TEXT_BASE  = 2'd0;
  localparam logic [1:0] CFG_TEXT_WORDS = 2'd1;
  localparam logic [1:0] CFG_DATA_BASE  = 2'd2;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTIU = 6'h0b;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2b;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  typedef struct packed {
    logic [XLEN-1:0]         text_base;
    logic [TEXT_WORDS_W-1:0] text_words;
    logic [XLEN-1:0]         data_base;
  } cfg_t;

  typedef struct packed {
    logic                 halt;
    logic [XLEN-1:0]      exec_pc;
    logic [XLEN-1:0]      next_pc;
    logic                 reg_we;
    logic [REG_IDX_W-1:0] reg_index;
    logic [XLEN-1:0]      reg_value;
    logic                 is_load;
    logic                 mem_we;
    logic [XLEN-1:0]      mem_addr;
    logic [XLEN-1:0]      mem_value;
    logic                 bad;
  } exec_t;

endpackage

@@ rtl/mips_subset_execute.sv @@
// ----------------------------------------------------------------------------
// mips_subset_execute
// Executor for a MIPS32 integer subset with register file and data memory.
// ----------------------------------------------------------------------------
// The block retires one instruction per clock cycle as long as result_stall
// is low and instructions keep arriving; each instruction is held first in
// the read stage and then in the result register before its result appears.
// Registers are read from a synchronous register file as the instruction is
// taken, the instruction executes and reaches data memory as it moves into
// the result stage, and the register write happens when the result transfer
// completes, with forwarding from the result stage and a write-through read
// path. The program counter advances with each executed instruction, so
// instr_word must be the word at the last next_pc. After reset the register
// file and data memory are cleared, one word per cycle; instr_stall stays
// high during that time while configuration writes are taken as usual.
module mips_subset_execute #(
  parameter int DATA_WORDS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mse_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           instr_valid,
  output logic                           instr_stall,
  input  logic [31:0]                    instr_word,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [31:0]                    exec_pc,
  output logic [31:0]                    next_pc,
  output logic                           reg_we,
  output logic [4:0]                     reg_index,
  output logic [31:0]                    reg_value,
  output logic                           mem_we,
  output logic [31:0]                    mem_addr,
  output logic [31:0]                    mem_value,
  output logic                           bad_access,
  output logic                           halted
);

  localparam int ADDR_W  = $clog2(DATA_WORDS);
  localparam int CLR_LEN = (DATA_WORDS > mse_pkg::REG_COUNT) ? DATA_WORDS
                                                              : mse_pkg::REG_COUNT;
  localparam int CLR_W   = $clog2(CLR_LEN);

  mse_pkg::cfg_t             cfg;
  logic [31:0]               pc;
  logic                      stopped;
  logic                      clearing;
  logic [CLR_W-1:0]          clr_cnt;
  logic                      s1_valid;
  logic [31:0]               s1_instr;
  logic                      out_valid;
  mse_pkg::exec_t            out_q;
  logic [31:0]               dmem_rdata;
  logic [31:0]               dmem [DATA_WORDS];

  logic                      adv;
  logic                      accept;
  logic                      retire;
  logic                      cfg_wr;
  logic [31:0]               rf_a;
  logic [31:0]               rf_b;
  logic [31:0]               op_a;
  logic [31:0]               op_b;
  logic [31:0]               load_data;
  mse_pkg::exec_t            res;
  logic [ADDR_W-1:0]         slot;
  logic                      rf_we;
  logic [4:0]                rf_waddr;
  logic [31:0]               rf_wdata;
  logic                      dmem_we;
  logic                      dmem_re;
  logic [ADDR_W-1:0]         dmem_waddr;
  logic [31:0]               dmem_wdata;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite;
  assign adv         = !(out_valid && result_stall);
  assign instr_stall = !adv || clearing;
  assign accept      = instr_valid && !instr_stall;
  assign retire      = out_valid && !result_stall;

  always_comb begin
    case (paddr[3:2])
      mse_pkg::CFG_TEXT_BASE:  prdata = cfg.text_base;
      mse_pkg::CFG_TEXT_WORDS: prdata = 32'(cfg.text_words);
      mse_pkg::CFG_DATA_BASE:  prdata = cfg.data_base;
      default:                 prdata = '0;
    endcase
  end

  // Result stage. Load data comes straight from the data memory read register.
  assign load_data    = out_q.bad ? 32'd0 : dmem_rdata;
  assign result_valid = out_valid;
  assign exec_pc      = out_q.exec_pc;
  assign next_pc      = out_q.next_pc;
  assign reg_we       = out_q.reg_we;
  assign reg_index    = out_q.reg_index;
  assign reg_value    = (out_q.is_load && out_q.reg_we) ? load_data : out_q.reg_value;
  assign mem_we       = out_q.mem_we;
  assign mem_addr     = out_q.mem_addr;
  assign mem_value    = out_q.is_load ? load_data : out_q.mem_value;
  assign bad_access   = out_q.bad;
  assign halted       = out_q.halt;

  assign rf_we    = clearing ? ({1'b0, clr_cnt} < (CLR_W + 1)'(mse_pkg::REG_COUNT))
                             : (retire && reg_we);
  assign rf_waddr = clearing ? clr_cnt[4:0] : reg_index;
  assign rf_wdata = clearing ? 32'd0 : reg_value;

  mse_regfile u_regfile (
    .clk     (clk),
    .rd_en   (accept),
    .ra_addr (instr_word[25:21]),
    .rb_addr (instr_word[20:16]),
    .ra_data (rf_a),
    .rb_data (rf_b),
    .wr_en   (rf_we),
    .wr_addr (rf_waddr),
    .wr_data (rf_wdata)
  );

  // The instruction ahead of the one in execute has not yet written back.
  assign op_a = (out_valid && reg_we && reg_index == s1_instr[25:21]) ? reg_value : rf_a;
  assign op_b = (out_valid && reg_we && reg_index == s1_instr[20:16]) ? reg_value : rf_b;

  mse_exec #(
    .DATA_WORDS (DATA_WORDS)
  ) u_exec (
    .instr   (s1_instr),
    .pc      (pc),
    .a       (op_a),
    .b       (op_b),
    .cfg     (cfg),
    .stopped (stopped),
    .res     (res),
    .slot    (slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_base  <= mse_pkg::TEXT_BASE_RST;
      cfg.text_words <= mse_pkg::TEXT_WORDS_RST;
      cfg.data_base  <= mse_pkg::DATA_BASE_RST;
      pc             <= mse_pkg::TEXT_BASE_RST;
      stopped        <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        mse_pkg::CFG_TEXT_BASE: begin
          cfg.text_base <= pwdata;
          pc            <= pwdata;
        end
        mse_pkg::CFG_TEXT_WORDS: cfg.text_words <= pwdata[mse_pkg::TEXT_WORDS_W-1:0];
        mse_pkg::CFG_DATA_BASE:  cfg.data_base  <= pwdata;
        default: ;
      endcase
    end else if (adv && s1_valid) begin
      pc <= res.next_pc;
      if (res.halt) begin
        stopped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= accept;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr <= instr_word;
    end
    if (adv && s1_valid) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == CLR_W'(CLR_LEN - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign dmem_we    = clearing ? ({1'b0, clr_cnt} < (CLR_W + 1)'(DATA_WORDS))
                               : (adv && s1_valid && res.mem_we);
  assign dmem_waddr = clearing ? clr_cnt[ADDR_W-1:0] : slot;
  assign dmem_wdata = clearing ? 32'd0 : res.mem_value;
  assign dmem_re    = adv && s1_valid && res.is_load && !res.bad;

  always_ff @(posedge clk) begin
    if (dmem_we) begin
      dmem[dmem_waddr] <= dmem_wdata;
    end
    if (dmem_re) begin
      dmem_rdata <= dmem[slot];
    end
  end

  a_zero_reg_kept: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(reg_we && reg_index == mse_pkg::ZERO_REG))
    else $error("Register zero reported as written.");

  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    (result_valid && halted) |-> (!reg_we && !mem_we && !bad_access && next_pc == exec_pc))
    else $error("Halted result carries a side effect.");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("Halt state cleared without reset.");

  a_store_in_window: assert property (@(posedge clk) disable iff (rst)
    (result_valid && mem_we) |-> !bad_access)
    else $error("Store outside the data window wrote memory.");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!s1_valid && !out_valid))
    else $error("Instruction in flight during memory clear.");

endmodule

@@ rtl/mse_regfile.sv @@
// ----------------------------------------------------------------------------
// mse_regfile
// Register file memory with two synchronous read ports and one write port.
// A read at the edge of a write to the same register returns the new value.
// ----------------------------------------------------------------------------
module mse_regfile (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [mse_pkg::REG_IDX_W-1:0] ra_addr,
  input  logic [mse_pkg::REG_IDX_W-1:0] rb_addr,
  output logic [mse_pkg::XLEN-1:0]      ra_data,
  output logic [mse_pkg::XLEN-1:0]      rb_data,
  input  logic                          wr_en,
  input  logic [mse_pkg::REG_IDX_W-1:0] wr_addr,
  input  logic [mse_pkg::XLEN-1:0]      wr_data
);

  logic [mse_pkg::XLEN-1:0] mem [mse_pkg::REG_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ra_data <= (wr_en && wr_addr == ra_addr) ? wr_data : mem[ra_addr];
      rb_data <= (wr_en && wr_addr == rb_addr) ? wr_data : mem[rb_addr];
    end
  end

endmodule

@@ rtl/mse_exec.sv @@
// ----------------------------------------------------------------------------
// mse_exec
// Decode and execute of one instruction: halt test, register result, branch
// and jump targets, and the effective address and window check of LW and SW.
// ----------------------------------------------------------------------------
module mse_exec #(
  parameter int DATA_WORDS = 1024
) (
  input  logic [mse_pkg::XLEN-1:0]  instr,
  input  logic [mse_pkg::XLEN-1:0]  pc,
  input  logic [mse_pkg::XLEN-1:0]  a,
  input  logic [mse_pkg::XLEN-1:0]  b,
  input  mse_pkg::cfg_t             cfg,
  input  logic                      stopped,
  output mse_pkg::exec_t            res,
  output logic [$clog2(DATA_WORDS)-1:0] slot
);

  localparam int ADDR_W = $clog2(DATA_WORDS);
  localparam logic [mse_pkg::XLEN-1:0] WIN_BYTES = 32'(DATA_WORDS * 4);

  logic [5:0]                     op;
  logic [5:0]                     fn;
  logic [mse_pkg::REG_IDX_W-1:0]  rt;
  logic [mse_pkg::REG_IDX_W-1:0]  rd;
  logic [4:0]                     sh;
  logic [mse_pkg::XLEN-1:0]       imm;
  logic [mse_pkg::XLEN-1:0]       simm;
  logic [mse_pkg::XLEN-1:0]       seq;
  logic [mse_pkg::XLEN-1:0]       btarget;
  logic [mse_pkg::XLEN-1:0]       jtarget;
  logic [mse_pkg::XLEN-1:0]       maddr;
  logic [mse_pkg::XLEN-1:0]       off;
  logic [mse_pkg::XLEN-1:0]       text_off;
  logic                           in_window;
  logic                           past_text;

  assign op        = instr[31:26];
  assign rt        = instr[20:16];
  assign rd        = instr[15:11];
  assign sh        = instr[10:6];
  assign fn        = instr[5:0];
  assign imm       = {16'h0000, instr[15:0]};
  assign simm      = {{16{instr[15]}}, instr[15:0]};
  assign seq       = pc + 32'd4;
  assign btarget   = seq + {simm[29:0], 2'b00};
  assign jtarget   = {seq[31:28], instr[25:0], 2'b00};
  assign maddr     = a + simm;
  assign off       = maddr - cfg.data_base;
  assign in_window = off < WIN_BYTES;
  assign slot      = off[ADDR_W+1:2];
  assign text_off  = pc - cfg.text_base;
  assign past_text = text_off[31:2] >= 30'(cfg.text_words);

  always_comb begin
    res         = '0;
    res.exec_pc = pc;
    res.next_pc = seq;
    unique case (op)
      mse_pkg::OP_RTYPE: begin
        res.reg_index = rd;
        res.reg_we    = 1'b1;
        unique case (fn)
          mse_pkg::FN_SLL:  res.reg_value = b << sh;
          mse_pkg::FN_SRL:  res.reg_value = b >> sh;
          mse_pkg::FN_JR: begin
            res.reg_we  = 1'b0;
            res.next_pc = a;
          end
          mse_pkg::FN_ADDU: res.reg_value = a + b;
          mse_pkg::FN_SUBU: res.reg_value = a - b;
          mse_pkg::FN_AND:  res.reg_value = a & b;
          mse_pkg::FN_OR:   res.reg_value = a | b;
          mse_pkg::FN_NOR:  res.reg_value = ~(a | b);
          mse_pkg::FN_SLTU: res.reg_value = {31'd0, a < b};
          default:          res.reg_we    = 1'b0;
        endcase
      end
      mse_pkg::OP_J: res.next_pc = jtarget;
      mse_pkg::OP_JAL: begin
        res.next_pc   = jtarget;
        res.reg_we    = 1'b1;
        res.reg_index = mse_pkg::LINK_REG;
        res.reg_value = seq;
      end
      mse_pkg::OP_BEQ: begin
        if (a == b) begin
          res.next_pc = btarget;
        end
      end
      mse_pkg::OP_BNE: begin
        if (a != b) begin
          res.next_pc = btarget;
        end
      end
      mse_pkg::OP_ADDIU: begin
        res.reg_we    = 1'b1;
        res.reg_index = rt;
        res.reg_value = a + simm;
      end
      mse_pkg::OP_SLTIU: begin
        res.reg_we    = 1'b1;
        res.reg_index = rt;
        res.reg_value = {31'd0, a < simm};
      end
      mse_pkg::OP_ANDI: begin
        res.reg_we    = 1'b1;
        res.reg_index = rt;
        res.reg_value = a & imm;
      end
      mse_pkg::OP_ORI: begin
        res.reg_we    = 1'b1;
        res.reg_index = rt;
        res.reg_value = a | imm;
      end
      mse_pkg::OP_LUI: begin
        res.reg_we    = 1'b1;
        res.reg_index = rt;
        res.reg_value = {instr[15:0], 16'h0000};
      end
      mse_pkg::OP_LW: begin
        res.is_load   = 1'b1;
        res.reg_we    = 1'b1;
        res.reg_index = rt;
        res.mem_addr  = maddr;
        res.bad       = !in_window;
      end
      mse_pkg::OP_SW: begin
        res.mem_addr  = maddr;
        res.mem_value = b;
        res.mem_we    = in_window;
        res.bad       = !in_window;
      end
      default: ;
    endcase

    if (res.reg_we && res.reg_index == mse_pkg::ZERO_REG) begin
      res.reg_we = 1'b0;
    end
    if (!res.reg_we) begin
      res.reg_index = '0;
      res.reg_value = '0;
    end

    // Once the program counter has left the text, nothing executes again.
    if (stopped || past_text) begin
      res         = '0;
      res.halt    = 1'b1;
      res.exec_pc = pc;
      res.next_pc = pc;
    end
  end

endmodule

@@ verif/mips_subset_execute_test.sv @@
// ----------------------------------------------------------------------------
// mips_subset_execute_test
// Self-checking bench for the MIPS integer subset executor. A behavioral
// model of the processor state predicts every retired instruction, and each
// transfer on the result channel is checked against it field by field. The
// stimulus is a directed program followed by random programs under several
// text and data window settings, with random idling on both channels. The
// run ends with the halt behavior, since only reset leaves the halted state.
// ----------------------------------------------------------------------------
module mips_subset_execute_test;

  localparam int MEM_WORDS   = 1024;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] exec_pc;
    logic [31:0] next_pc;
    logic        reg_we;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_we;
    logic [31:0] mem_addr;
    logic [31:0] mem_value;
    logic        bad_access;
    logic        halted;
  } retire_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [mse_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        instr_valid, instr_stall;
  logic [31:0] instr_word;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] exec_pc, next_pc, reg_value, mem_addr, mem_value;
  logic        reg_we, mem_we, bad_access, halted;
  logic [4:0]  reg_index;

  logic [31:0] text_base;
  logic [20:0] text_words;
  logic [31:0] data_base;
  logic [31:0] cur_pc;
  logic [31:0] gpr [32];
  logic [31:0] dmem [MEM_WORDS];
  logic        halt_latched;

  retire_t expected_q [$];
  int fail_count  = 0;
  int cycle_count = 0;
  int stall_left  = 0;
  bit calm        = 1'b0;

  mips_subset_execute #(.DATA_WORDS(MEM_WORDS)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .instr_valid(instr_valid), .instr_stall(instr_stall), .instr_word(instr_word),
    .result_valid(result_valid), .result_stall(result_stall),
    .exec_pc(exec_pc), .next_pc(next_pc), .reg_we(reg_we), .reg_index(reg_index),
    .reg_value(reg_value), .mem_we(mem_we), .mem_addr(mem_addr),
    .mem_value(mem_value), .bad_access(bad_access), .halted(halted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                        input logic [4:0] rd, input logic [4:0] sh,
                                        input logic [5:0] fn);
    return {mse_pkg::OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_j(input logic [5:0] op, input logic [25:0] tgt);
    return {op, tgt};
  endfunction

  function automatic logic [5:0] alu_fn(input int i);
    case (i)
      0: return mse_pkg::FN_SLL;
      1: return mse_pkg::FN_SRL;
      2: return mse_pkg::FN_ADDU;
      3: return mse_pkg::FN_SUBU;
      4: return mse_pkg::FN_AND;
      5: return mse_pkg::FN_OR;
      6: return mse_pkg::FN_NOR;
      default: return mse_pkg::FN_SLTU;
    endcase
  endfunction

  function automatic logic [5:0] imm_op(input int i);
    case (i)
      0: return mse_pkg::OP_ADDIU;
      1: return mse_pkg::OP_SLTIU;
      2: return mse_pkg::OP_ANDI;
      3: return mse_pkg::OP_ORI;
      default: return mse_pkg::OP_LUI;
    endcase
  endfunction

  function automatic bit known_op(input logic [5:0] op);
    case (op)
      mse_pkg::OP_RTYPE, mse_pkg::OP_J, mse_pkg::OP_JAL, mse_pkg::OP_BEQ,
      mse_pkg::OP_BNE, mse_pkg::OP_ADDIU, mse_pkg::OP_SLTIU, mse_pkg::OP_ANDI,
      mse_pkg::OP_ORI, mse_pkg::OP_LUI, mse_pkg::OP_LW, mse_pkg::OP_SW:
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit known_fn(input logic [5:0] fn);
    case (fn)
      mse_pkg::FN_SLL, mse_pkg::FN_SRL, mse_pkg::FN_JR, mse_pkg::FN_ADDU,
      mse_pkg::FN_SUBU, mse_pkg::FN_AND, mse_pkg::FN_OR, mse_pkg::FN_NOR,
      mse_pkg::FN_SLTU:
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit in_text(input logic [31:0] pc);
    return ((pc - text_base) >> 2) < {11'd0, text_words};
  endfunction

  // Where the instruction would send the program counter, without retiring it.
  function automatic logic [31:0] target_of(input logic [31:0] w);
    logic [31:0] seq, simm;
    seq  = cur_pc + 32'd4;
    simm = {{16{w[15]}}, w[15:0]};
    case (w[31:26])
      mse_pkg::OP_RTYPE: return (w[5:0] == mse_pkg::FN_JR) ? gpr[w[25:21]] : seq;
      mse_pkg::OP_J, mse_pkg::OP_JAL: return {seq[31:28], w[25:0], 2'b00};
      mse_pkg::OP_BEQ:
        return (gpr[w[25:21]] == gpr[w[20:16]]) ? seq + (simm << 2) : seq;
      mse_pkg::OP_BNE:
        return (gpr[w[25:21]] != gpr[w[20:16]]) ? seq + (simm << 2) : seq;
      default: return seq;
    endcase
  endfunction

  function automatic logic [31:0] near_target();
    int s, k;
    s = int'((cur_pc - text_base) >> 2);
    k = s + int'($urandom_range(0, 256)) - 128;
    if (k < 0) k = 0;
    if (k >= int'(text_words)) k = int'(text_words) - 1;
    return text_base + 32'(4 * k);
  endfunction

  function automatic retire_t retire(input logic [31:0] w);
    retire_t     r;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh, widx;
    logic [31:0] a, b, seq, npc, simm, imm, wval, off;
    logic        we;
    r    = '0;
    op   = w[31:26];
    rs   = w[25:21];
    rt   = w[20:16];
    rd   = w[15:11];
    sh   = w[10:6];
    fn   = w[5:0];
    a    = gpr[rs];
    b    = gpr[rt];
    simm = {{16{w[15]}}, w[15:0]};
    imm  = {16'd0, w[15:0]};
    seq  = cur_pc + 32'd4;
    npc  = seq;
    we   = 1'b0;
    widx = mse_pkg::ZERO_REG;
    wval = '0;
    if (halt_latched || !in_text(cur_pc)) begin
      halt_latched = 1'b1;
      r.exec_pc    = cur_pc;
      r.next_pc    = cur_pc;
      r.halted     = 1'b1;
      return r;
    end
    case (op)
      mse_pkg::OP_RTYPE: begin
        widx = rd;
        we   = 1'b1;
        case (fn)
          mse_pkg::FN_SLL:  wval = b << sh;
          mse_pkg::FN_SRL:  wval = b >> sh;
          mse_pkg::FN_JR: begin
            we  = 1'b0;
            npc = a;
          end
          mse_pkg::FN_ADDU: wval = a + b;
          mse_pkg::FN_SUBU: wval = a - b;
          mse_pkg::FN_AND:  wval = a & b;
          mse_pkg::FN_OR:   wval = a | b;
          mse_pkg::FN_NOR:  wval = ~(a | b);
          mse_pkg::FN_SLTU: wval = (a < b) ? 32'd1 : 32'd0;
          default: we = 1'b0;
        endcase
      end
      mse_pkg::OP_J: npc = {seq[31:28], w[25:0], 2'b00};
      mse_pkg::OP_JAL: begin
        npc  = {seq[31:28], w[25:0], 2'b00};
        we   = 1'b1;
        widx = mse_pkg::LINK_REG;
        wval = seq;
      end
      mse_pkg::OP_BEQ: if (a == b) npc = seq + (simm << 2);
      mse_pkg::OP_BNE: if (a != b) npc = seq + (simm << 2);
      mse_pkg::OP_ADDIU: begin we = 1'b1; widx = rt; wval = a + simm; end
      mse_pkg::OP_SLTIU: begin
        we   = 1'b1;
        widx = rt;
        wval = (a < simm) ? 32'd1 : 32'd0;
      end
      mse_pkg::OP_ANDI:  begin we = 1'b1; widx = rt; wval = a & imm; end
      mse_pkg::OP_ORI:   begin we = 1'b1; widx = rt; wval = a | imm; end
      mse_pkg::OP_LUI:   begin we = 1'b1; widx = rt; wval = imm << 16; end
      mse_pkg::OP_LW: begin
        r.mem_addr = a + simm;
        off = r.mem_addr - data_base;
        if (off < 32'(MEM_WORDS * 4)) r.mem_value = dmem[int'(off >> 2)];
        else r.bad_access = 1'b1;
        we   = 1'b1;
        widx = rt;
        wval = r.mem_value;
      end
      mse_pkg::OP_SW: begin
        r.mem_addr  = a + simm;
        r.mem_value = b;
        off = r.mem_addr - data_base;
        if (off < 32'(MEM_WORDS * 4)) begin
          dmem[int'(off >> 2)] = b;
          r.mem_we = 1'b1;
        end else begin
          r.bad_access = 1'b1;
        end
      end
      default: ;
    endcase
    if (we && widx == mse_pkg::ZERO_REG) we = 1'b0;
    if (we) begin
      gpr[widx] = wval;
    end else begin
      widx = mse_pkg::ZERO_REG;
      wval = '0;
    end
    cur_pc      = npc;
    r.exec_pc   = seq - 32'd4;
    r.next_pc   = npc;
    r.reg_we    = we;
    r.reg_index = widx;
    r.reg_value = wval;
    return r;
  endfunction

  function automatic string describe(input retire_t r);
    return $sformatf("pc %h next %h reg %b r%0d=%h mem %b @%h=%h bad %b halt %b",
                     r.exec_pc, r.next_pc, r.reg_we, r.reg_index, r.reg_value,
                     r.mem_we, r.mem_addr, r.mem_value, r.bad_access, r.halted);
  endfunction

  task automatic flag_error(input string msg);
    if (fail_count < 10) $display("%s", msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : check_result
    retire_t got, want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      got = {exec_pc, next_pc, reg_we, reg_index, reg_value, mem_we, mem_addr,
             mem_value, bad_access, halted};
      if (expected_q.size() == 0) begin
        flag_error($sformatf("unexpected transfer: %s", describe(got)));
      end else begin
        want = expected_q.pop_front();
        if (got.exec_pc !== want.exec_pc || got.next_pc !== want.next_pc ||
            got.reg_we !== want.reg_we || got.reg_index !== want.reg_index ||
            got.reg_value !== want.reg_value || got.mem_we !== want.mem_we ||
            got.mem_addr !== want.mem_addr || got.mem_value !== want.mem_value ||
            got.bad_access !== want.bad_access || got.halted !== want.halted)
          flag_error($sformatf("mismatch\n  expected %s\n  actual   %s",
                               describe(want), describe(got)));
      end
    end
  end

  always @(negedge clk) begin
    if (rst || calm) begin
      result_stall = 1'b0;
      stall_left   = 0;
    end else if (stall_left > 0) begin
      result_stall = 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      result_stall = 1'b1;
      stall_left   = $urandom_range(0, 8);
    end else begin
      result_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_instr(input logic [31:0] w);
    if (!calm && $urandom_range(0, 5) == 0) begin
      instr_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    instr_valid = 1'b1;
    instr_word  = w;
    do @(posedge clk); while (instr_stall !== 1'b0);
    expected_q.push_back(retire(w));
    @(negedge clk);
  endtask

  // Anything that would leave the text is replaced by a branch back to its start.
  task automatic emit(input logic [31:0] w);
    logic [31:0] back;
    if (!in_text(target_of(w))) begin
      back = text_base - (cur_pc + 32'd4);
      w = enc_i(mse_pkg::OP_BEQ, mse_pkg::ZERO_REG, mse_pkg::ZERO_REG, back[17:2]);
      if (!in_text(target_of(w)))
        w = enc_i(mse_pkg::OP_BEQ, mse_pkg::ZERO_REG, mse_pkg::ZERO_REG,
                  back[17:2] + 16'd1);
    end
    send_instr(w);
  endtask

  task automatic wait_drained();
    instr_valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_read(input logic [1:0] idx, input logic [31:0] want);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want)
      flag_error($sformatf("register %0d read %h, expected %h", idx, prdata, want));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    instr_valid = 1'b0;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      mse_pkg::CFG_TEXT_BASE: begin
        text_base = value;
        cur_pc    = value;
      end
      mse_pkg::CFG_TEXT_WORDS: text_words = value[20:0];
      mse_pkg::CFG_DATA_BASE:  data_base  = value;
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    cfg_read(idx, (idx == mse_pkg::CFG_TEXT_WORDS) ? {11'd0, value[20:0]} : value);
  endtask

  task automatic run_program(input int count);
    int          n, kind, reps;
    logic [4:0]  ra, rb;
    logic [5:0]  op;
    logic [31:0] dest;
    logic [15:0] off;
    n = 0;
    while (n < count) begin
      kind = $urandom_range(0, 99);
      ra   = 5'($urandom_range(1, 31));
      rb   = 5'($urandom_range(0, 31));
      if (kind < 30) begin
        emit(enc_r(5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
                   alu_fn($urandom_range(0, 7))));
        n++;
      end else if (kind < 50) begin
        emit(enc_i(imm_op($urandom_range(0, 4)), 5'($urandom), 5'($urandom),
                   16'($urandom)));
        n++;
      end else if (kind < 65) begin
        emit(enc_i(mse_pkg::OP_LUI, mse_pkg::ZERO_REG, ra, data_base[31:16]));
        emit(enc_i(mse_pkg::OP_ORI, ra, ra, data_base[15:0]));
        n += 2;
        reps = $urandom_range(1, 4);
        repeat (reps) begin
          case ($urandom_range(0, 7))
            6: off = 16'($urandom_range(MEM_WORDS * 4 - 4, MEM_WORDS * 4 + 3));
            7: off = 16'($urandom);
            default: off = 16'($urandom_range(0, MEM_WORDS * 4 - 1));
          endcase
          emit(enc_i($urandom_range(0, 1) ? mse_pkg::OP_LW : mse_pkg::OP_SW, ra,
                     5'($urandom), off));
          n++;
        end
      end else if (kind < 80) begin
        if ($urandom_range(0, 2) == 0) rb = ra;
        dest = near_target() - (cur_pc + 32'd4);
        emit(enc_i($urandom_range(0, 1) ? mse_pkg::OP_BEQ : mse_pkg::OP_BNE, ra, rb,
                   dest[17:2]));
        n++;
      end else if (kind < 88) begin
        dest = near_target();
        emit(enc_j($urandom_range(0, 1) ? mse_pkg::OP_J : mse_pkg::OP_JAL, dest[27:2]));
        n++;
      end else if (kind < 93) begin
        dest = near_target();
        emit(enc_i(mse_pkg::OP_LUI, mse_pkg::ZERO_REG, ra, dest[31:16]));
        emit(enc_i(mse_pkg::OP_ORI, ra, ra, dest[15:0]));
        emit(enc_r(ra, mse_pkg::ZERO_REG, mse_pkg::ZERO_REG, 5'd0, mse_pkg::FN_JR));
        n += 3;
      end else if (kind < 97) begin
        if ($urandom_range(0, 1)) begin
          do op = 6'($urandom); while (known_op(op));
          emit({op, 26'($urandom)});
        end else begin
          do op = 6'($urandom); while (known_fn(op));
          emit({mse_pkg::OP_RTYPE, 20'($urandom), op});
        end
        n++;
      end else begin
        emit($urandom);
        n++;
      end
    end
  endtask

  task automatic test_reset_values();
    cfg_read(mse_pkg::CFG_TEXT_BASE, mse_pkg::TEXT_BASE_RST);
    cfg_read(mse_pkg::CFG_TEXT_WORDS, {11'd0, mse_pkg::TEXT_WORDS_RST});
    cfg_read(mse_pkg::CFG_DATA_BASE, mse_pkg::DATA_BASE_RST);
  endtask

  task automatic test_directed_program();
    logic [31:0] dest;
    cfg_write(mse_pkg::CFG_TEXT_WORDS, 32'h0010_0000);
    emit(enc_i(mse_pkg::OP_LUI, mse_pkg::ZERO_REG, 5'd1, data_base[31:16]));
    emit(enc_i(mse_pkg::OP_ORI, 5'd1, 5'd1, data_base[15:0]));
    emit(enc_i(mse_pkg::OP_ADDIU, mse_pkg::ZERO_REG, 5'd4, 16'hFFFF));
    emit(enc_i(mse_pkg::OP_ORI, mse_pkg::ZERO_REG, 5'd2, 16'hFFFF));
    emit(enc_i(mse_pkg::OP_ANDI, 5'd4, 5'd3, 16'h8000));
    emit(enc_i(mse_pkg::OP_SLTIU, 5'd2, 5'd5, 16'hFFFF));
    emit(enc_i(mse_pkg::OP_SLTIU, 5'd4, 5'd6, 16'h0001));
    emit(enc_r(5'd4, 5'd2, 5'd7, 5'd0, mse_pkg::FN_ADDU));
    emit(enc_r(mse_pkg::ZERO_REG, 5'd2, 5'd8, 5'd0, mse_pkg::FN_SUBU));
    emit(enc_r(5'd4, 5'd2, 5'd9, 5'd0, mse_pkg::FN_AND));
    emit(enc_r(5'd3, 5'd2, 5'd10, 5'd0, mse_pkg::FN_OR));
    emit(enc_r(mse_pkg::ZERO_REG, mse_pkg::ZERO_REG, 5'd11, 5'd0, mse_pkg::FN_NOR));
    emit(enc_r(5'd2, 5'd4, 5'd12, 5'd0, mse_pkg::FN_SLTU));
    emit(enc_r(mse_pkg::ZERO_REG, 5'd4, 5'd13, 5'd31, mse_pkg::FN_SLL));
    emit(enc_r(mse_pkg::ZERO_REG, 5'd4, 5'd14, 5'd31, mse_pkg::FN_SRL));
    emit(enc_i(mse_pkg::OP_SW, 5'd1, 5'd4, 16'd0));
    emit(enc_i(mse_pkg::OP_SW, 5'd1, 5'd2, 16'(MEM_WORDS * 4 - 4)));
    emit(enc_i(mse_pkg::OP_LW, 5'd1, 5'd15, 16'(MEM_WORDS * 4 - 2)));
    emit(enc_i(mse_pkg::OP_LW, 5'd1, 5'd16, 16'(MEM_WORDS * 4)));
    emit(enc_i(mse_pkg::OP_SW, 5'd1, 5'd4, 16'hFFFC));
    emit(enc_i(mse_pkg::OP_ADDIU, 5'd4, mse_pkg::ZERO_REG, 16'd5));
    emit(enc_i(mse_pkg::OP_BEQ, 5'd4, 5'd4, 16'd3));
    emit(enc_i(mse_pkg::OP_BNE, 5'd4, 5'd4, 16'd7));
    emit(enc_i(mse_pkg::OP_BNE, 5'd4, 5'd2, 16'hFFFE));
    dest = cur_pc + 32'd64;
    emit(enc_j(mse_pkg::OP_JAL, dest[27:2]));
    emit(enc_r(mse_pkg::LINK_REG, mse_pkg::ZERO_REG, mse_pkg::ZERO_REG, 5'd0,
               mse_pkg::FN_JR));
    dest = cur_pc + 32'd32;
    emit(enc_j(mse_pkg::OP_J, dest[27:2]));
    emit({6'h3F, 26'h2AA_AAAA});
    emit(enc_r(5'd4, 5'd4, 5'd20, 5'd5, 6'h3F));
    wait_drained();
  endtask

  task automatic test_wrapped_windows();
    cfg_write(mse_pkg::CFG_TEXT_BASE, 32'hFFFF_FFFF);
    cfg_write(mse_pkg::CFG_DATA_BASE, 32'hFFFF_FFFF);
    run_program(380);
    wait_drained();
  endtask

  task automatic test_short_text();
    cfg_write(mse_pkg::CFG_TEXT_BASE, 32'h0000_0000);
    cfg_write(mse_pkg::CFG_TEXT_WORDS, 32'd64);
    cfg_write(mse_pkg::CFG_DATA_BASE, 32'h0000_0000);
    run_program(150);
    wait_drained();
    run_program(150);
    wait_drained();
  endtask

  task automatic test_unaligned_data();
    cfg_write(mse_pkg::CFG_TEXT_BASE, 32'h0FFF_FF00);
    cfg_write(mse_pkg::CFG_TEXT_WORDS, 32'h0010_0000);
    cfg_write(mse_pkg::CFG_DATA_BASE, 32'h1234_5678);
    run_program(500);
    wait_drained();
  endtask

  task automatic test_steady_flow();
    calm = 1'b1;
    cfg_write(mse_pkg::CFG_TEXT_BASE, mse_pkg::TEXT_BASE_RST);
    cfg_write(mse_pkg::CFG_DATA_BASE, mse_pkg::DATA_BASE_RST);
    run_program(320);
    wait_drained();
  endtask

  // The text is made short so that straight-line code runs off its end.
  task automatic test_halt();
    cfg_write(mse_pkg::CFG_TEXT_WORDS, 32'd8);
    cfg_write(mse_pkg::CFG_TEXT_BASE, mse_pkg::TEXT_BASE_RST);
    repeat (12)
      send_instr(enc_i(mse_pkg::OP_ADDIU, 5'($urandom), 5'($urandom), 16'($urandom)));
    wait_drained();
    cfg_write(mse_pkg::CFG_TEXT_BASE, 32'h0050_0000);
    cfg_write(mse_pkg::CFG_TEXT_WORDS, 32'd0);
    repeat (3) send_instr($urandom);
    wait_drained();
  endtask

  initial begin
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    instr_valid  = 1'b0;
    instr_word   = '0;
    text_base    = mse_pkg::TEXT_BASE_RST;
    text_words   = mse_pkg::TEXT_WORDS_RST;
    data_base    = mse_pkg::DATA_BASE_RST;
    cur_pc       = mse_pkg::TEXT_BASE_RST;
    halt_latched = 1'b0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_directed_program();
    test_wrapped_windows();
    test_short_text();
    test_unaligned_data();
    test_steady_flow();
    test_halt();

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mse_pkg.sv
rtl/mse_regfile.sv
rtl/mse_exec.sv
rtl/mips_subset_execute.sv
verif/mips_subset_execute_test.sv
